[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, reset disables
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/kvib_pkg.sv]
`default_nettype none
package kvib_pkg;

	localparam int unsigned DEF_SLOTS    = 16;
	localparam int unsigned SLOT_W       = 5;
	localparam int unsigned FIFO_DEPTH   = 4;
	localparam int unsigned FIFO_PTR_W   = 2;
	localparam int unsigned FIFO_CNT_W   = 3;
	localparam int unsigned MASK_W       = 22;
	localparam logic [15:0] PAGE_SIZE_RST = 16'd16;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_COUNT = 2'd1;
	localparam logic [1:0] ERR_FILL  = 2'd2;

	localparam logic KIND_PAGE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        first_of_batch;
		logic [7:0]  page_count;
		logic [23:0] key_length;
		logic [31:0] page_id;
	} slot_word_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] page_out;
		logic [15:0] query_end;
		logic [31:0] page_offset_end;
		logic [15:0] last_page_fill;
		logic [31:0] mask_offset_end;
		logic [1:0]  error_code;
		logic        last;
	} result_word_t;

	// classified slot handed from front to back
	typedef struct packed {
		logic              first;
		logic              page;
		logic              summary;
		logic [31:0]       page_id;
		logic [7:0]        count;
		logic [MASK_W-1:0] mask_bytes;
		logic [15:0]       fill;
		logic [1:0]        err;
	} op_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} fifo_ctl_t;

endpackage
`default_nettype wire

[rtl/kvib_front.sv]
`default_nettype none
module kvib_front import kvib_pkg::*; #(
	parameter int unsigned SLOTS = DEF_SLOTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        slot_valid,
	output logic             slot_stall,
	input  wire slot_word_t  slot_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        q_full,
	output logic             push,
	output op_t              op
);

	localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOTS - 1);
	localparam logic [7:0]        SLOT_CNT = 8'(SLOTS);

	logic [15:0]       psize_q;
	logic [SLOT_W-1:0] slot_q;
	logic              valid_s1;
	logic              first_s1;
	logic              page_s1;
	logic              sum_s1;
	logic [7:0]        count_s1;
	logic [23:0]       klen_s1;
	logic [31:0]       pid_s1;
	logic [23:0]       prod_s1;

	logic              accept;
	logic [SLOT_W-1:0] pos_c;
	logic [7:0]        cm1_c;
	logic [23:0]       prod_c;
	logic [24:0]       diff_c;
	logic [24:0]       mround_c;
	logic [1:0]        err_c;

	assign cfg_ready  = 1'b1;
	assign slot_stall = valid_s1 && q_full;
	assign accept     = slot_valid && !slot_stall;
	assign push       = valid_s1 && !q_full;

	assign pos_c  = slot_word.first_of_batch ? '0 : slot_q;
	assign cm1_c  = slot_word.page_count - 8'd1;
	assign prod_c = {16'd0, cm1_c} * {8'd0, psize_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q  <= PAGE_SIZE_RST;
			slot_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				psize_q <= cfg_data;
			end
			if (accept) begin
				slot_q <= (pos_c == LAST_POS) ? '0 : pos_c + 1'b1;
			end
			if (!valid_s1 || push) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (!valid_s1 || push)) begin
			first_s1 <= slot_word.first_of_batch;
			page_s1  <= {3'd0, pos_c} < slot_word.page_count;
			sum_s1   <= pos_c == LAST_POS;
			count_s1 <= slot_word.page_count;
			klen_s1  <= slot_word.key_length;
			pid_s1   <= slot_word.page_id;
			prod_s1  <= prod_c;
		end
	end

	assign diff_c   = {1'b0, klen_s1} - {1'b0, prod_s1};
	assign mround_c = {1'b0, klen_s1} + 25'd7;

	always_comb begin
		err_c = ERR_OK;
		if (count_s1 > SLOT_CNT) begin
			err_c = ERR_COUNT;
		end else if (count_s1 != 8'd0) begin
			if (diff_c[24] || diff_c == 25'd0 || diff_c[23:0] > {8'd0, psize_q}) begin
				err_c = ERR_FILL;
			end
		end
	end

	always_comb begin
		op.first      = first_s1;
		op.page       = page_s1;
		op.summary    = sum_s1;
		op.page_id    = pid_s1;
		op.count      = count_s1;
		op.mask_bytes = mround_c[24:3];
		op.err        = err_c;
		op.fill       = (err_c == ERR_OK && count_s1 != 8'd0) ? diff_c[15:0] : 16'd0;
	end

endmodule
`default_nettype wire

[rtl/kvib_fifo.sv]
`default_nettype none
module kvib_fifo import kvib_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  wr_op,
	input  wire logic pop,
	output op_t       rd_op,
	output fifo_ctl_t ctl
);

	op_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign ctl.push  = push;
	assign ctl.pop   = pop;
	assign ctl.full  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign ctl.empty = cnt_q == '0;
	assign rd_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule
`default_nettype wire

[rtl/kvib_back.sv]
`default_nettype none
module kvib_back import kvib_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire fifo_ctl_t q_ctl,
	input  wire op_t       op,
	output logic           pop,
	output logic           result_valid,
	input  wire logic      result_stall,
	output result_word_t   result_word
);

	logic         out_valid_q;
	result_word_t out_q;
	logic         phase_q;
	logic [15:0]  beam_total_q;
	logic [31:0]  page_sum_q;
	logic [31:0]  mask_sum_q;

	logic         have;
	logic         page_now;
	logic         emit;
	logic         split;
	logic         load_ok;
	logic         load;
	logic [15:0]  beam_base;
	logic [31:0]  page_base;
	logic [31:0]  mask_base;
	logic [15:0]  beam_new;
	logic [31:0]  page_new;
	logic [31:0]  mask_new;
	result_word_t res_c;

	assign have     = !q_ctl.empty;
	assign page_now = op.page && !phase_q;
	assign emit     = page_now || op.summary;
	assign split    = op.page && op.summary && !phase_q;
	assign load_ok  = !out_valid_q || !result_stall;
	assign load     = have && emit && load_ok;
	assign pop      = have && (emit ? (load_ok && !split) : 1'b1);

	assign beam_base = op.first ? '0 : beam_total_q;
	assign page_base = op.first ? '0 : page_sum_q;
	assign mask_base = op.first ? '0 : mask_sum_q;
	assign beam_new  = beam_base + 16'd1;
	assign page_new  = (op.err == ERR_OK) ? page_base + {24'd0, op.count} : page_base;
	assign mask_new  = (op.err == ERR_OK) ?
		mask_base + {{(32 - MASK_W){1'b0}}, op.mask_bytes} : mask_base;

	always_comb begin
		res_c = '0;
		if (page_now) begin
			res_c.kind     = KIND_PAGE;
			res_c.page_out = op.page_id;
			res_c.last     = !op.summary;
		end else begin
			res_c.kind            = KIND_SUMMARY;
			res_c.query_end       = beam_new;
			res_c.page_offset_end = page_new;
			res_c.last_page_fill  = op.fill;
			res_c.mask_offset_end = mask_new;
			res_c.error_code      = op.err;
			res_c.last            = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			phase_q      <= 1'b0;
			beam_total_q <= '0;
			page_sum_q   <= '0;
			mask_sum_q   <= '0;
		end else begin
			if (load_ok) begin
				out_valid_q <= load;
			end
			if (pop) begin
				phase_q <= 1'b0;
			end else if (load && split) begin
				phase_q <= 1'b1;
			end
			if (pop) begin
				beam_total_q <= op.summary ? beam_new : beam_base;
				page_sum_q   <= op.summary ? page_new : page_base;
				mask_sum_q   <= op.summary ? mask_new : mask_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_c;
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

endmodule
`default_nettype wire

[rtl/paged_kv_index_builder.sv]
`default_nettype none
// Paged KV index builder. Takes one page slot word per cycle (SLOTS_PER_BEAM
// slots per beam row) and returns page-list words for slots below the row's
// page count, plus a beam summary after the row's last slot. Input words are
// taken every cycle while the four-entry queue between front and back has room;
// the back delivers at most one result word per cycle and holds it while
// result_stall is high; a row's last slot can yield both a page word and a
// summary. A slot passes the front's stage register, the queue and the back's
// output register on its way to a result. The user must write the page size
// register over the cfg channel only while the block is idle; the block itself does not enforce this.
module paged_kv_index_builder import kvib_pkg::*; #(
	parameter int unsigned SLOTS_PER_BEAM = DEF_SLOTS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         slot_valid,
	output logic              slot_stall,
	input  wire slot_word_t   slot_word,
	output logic              result_valid,
	input  wire logic         result_stall,
	output result_word_t      result_word,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [15:0]  cfg_data
);

	logic      push;
	logic      pop;
	op_t       wr_op;
	op_t       rd_op;
	fifo_ctl_t q_ctl;

	kvib_front #(
		.SLOTS(SLOTS_PER_BEAM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_valid (slot_valid),
		.slot_stall (slot_stall),
		.slot_word  (slot_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_full     (q_ctl.full),
		.push       (push),
		.op         (wr_op)
	);

	kvib_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (wr_op),
		.pop    (pop),
		.rd_op  (rd_op),
		.ctl    (q_ctl)
	);

	kvib_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_ctl        (q_ctl),
		.op           (rd_op),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule
`default_nettype wire

[rtl/kvib_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module kvib_checker import kvib_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         result_valid,
	input wire logic         result_stall,
	input wire result_word_t result_word
);

	`ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_word))
	`ASSERT_IMP(a_page_clean, clk, arst_n, result_valid && result_word.kind == KIND_PAGE, result_word.error_code == ERR_OK && result_word.query_end == 16'd0 && result_word.last_page_fill == 16'd0)
	`ASSERT_IMP(a_sum_last, clk, arst_n, result_valid && result_word.kind == KIND_SUMMARY, result_word.last && result_word.page_out == 32'd0)
	`ASSERT_IMP(a_err_fill, clk, arst_n, result_valid && result_word.error_code != ERR_OK, result_word.last_page_fill == 16'd0 && result_word.kind == KIND_SUMMARY)

endmodule

bind paged_kv_index_builder kvib_checker u_kvib_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_word  (result_word)
);
`default_nettype wire
